/* hdl/calendar_clock_with_dst_assert.svh */
// Assertion macros for the calendar clock block.
`ifndef CALENDAR_CLOCK_WITH_DST_ASSERT_SVH
`define CALENDAR_CLOCK_WITH_DST_ASSERT_SVH

// Checked only out of reset.
`ifndef SYNTHESIS
`define CAL_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`else
`define CAL_ASSERT(name, clk, rst, prop, msg)
`endif

// Checked on every edge, reset included.
`ifndef SYNTHESIS
`define CAL_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CAL_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

/* hdl/cal_dst_pkg.sv */
// Types, constants and helper functions of the calendar clock block.
package cal_dst_pkg;

   typedef enum logic {
      CMD_TICK = 1'b0,
      CMD_LOAD = 1'b1
   } cal_cmd_type;

   localparam logic [5:0] SEC_MAX      = 6'd59;
   localparam logic [5:0] MIN_MAX      = 6'd59;
   localparam logic [4:0] HOUR_MAX     = 5'd23;
   localparam logic [4:0] DST_PRE_HOUR = 5'd2;   // hour before the turn to 3
   localparam logic [4:0] DST_FWD_HOUR = 5'd4;
   localparam logic [4:0] DST_BACK_HOUR = 5'd2;
   localparam logic [4:0] DST_MIN_DAY  = 5'd24;  // shift only after this day
   localparam logic [4:0] DAY_FEB      = 5'd28;
   localparam logic [4:0] DAY_FEB_LEAP = 5'd29;
   localparam logic [4:0] DAY_LONG     = 5'd31;
   localparam logic [4:0] DAY_SHORT    = 5'd30;
   localparam logic [4:0] DAY_FIRST    = 5'd1;
   localparam logic [3:0] MONTH_JAN    = 4'd1;
   localparam logic [3:0] MONTH_FEB    = 4'd2;
   localparam logic [3:0] MONTH_MAR    = 4'd3;
   localparam logic [3:0] MONTH_OCT    = 4'd10;
   localparam logic [3:0] MONTH_NOV    = 4'd11;
   localparam logic [3:0] MONTH_DEC    = 4'd12;
   localparam logic [2:0] WDAY_SUN     = 3'd0;
   localparam logic [2:0] WDAY_SAT     = 3'd6;
   // Years 2100 and 2200 as offsets from 2000: century years that are not leap.
   localparam logic [7:0] YEAR_2100    = 8'd100;
   localparam logic [7:0] YEAR_2200    = 8'd200;

   localparam logic [5:0] RST_SEC   = 6'd0;
   localparam logic [5:0] RST_MIN   = 6'd0;
   localparam logic [4:0] RST_HOUR  = 5'd0;
   localparam logic [4:0] RST_DAY   = 5'd1;
   localparam logic [3:0] RST_MONTH = 4'd1;
   localparam logic [7:0] RST_YEAR  = 8'd19;
   localparam logic [2:0] RST_WDAY  = 3'd2;

   typedef struct packed {
      cal_cmd_type command;
      logic [4:0]  load_hours;
      logic [5:0]  load_minutes;
      logic [5:0]  load_seconds;
      logic [4:0]  load_day;
      logic [3:0]  load_month;
      logic [7:0]  load_year;
      logic [2:0]  load_weekday;
   } cal_req_type;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic [4:0] day;
      logic [3:0] month;
      logic [7:0] year;
      logic [2:0] weekday;
      logic       leap_year;
      logic       day_rollover;
      logic       dst_shifted;
   } cal_rsp_type;

   // Gregorian rule over 2000..2255: every fourth year, minus 2100 and 2200.
   function automatic logic cal_leap(input logic [7:0] yr);
      return (yr[1:0] == 2'b00) && (yr != YEAR_2100) && (yr != YEAR_2200);
   endfunction

   function automatic logic cal_long_month(input logic [3:0] m);
      return (m == 4'd1) || (m == 4'd3) || (m == 4'd5) || (m == 4'd7) ||
             (m == 4'd8) || (m == 4'd10) || (m == MONTH_DEC);
   endfunction

endpackage

/* hdl/cal_dst_chan.sv */
// Valid/ready channel carrying one payload beat of a given type.
interface cal_dst_chan #(
   parameter type data_type = logic
);
   logic     valid;
   logic     ready;
   data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* hdl/calendar_clock_with_dst.sv */
// Top level: real-time calendar clock with leap years and daylight saving.
//
//  channel   dir  handshake       payload
//  req_chan  in   valid / ready   cal_req_type: tick or full date/time load
//  rsp_chan  out  valid / ready   cal_rsp_type: clock after the beat + flags
//  csr_*     in   csr_wr_en       csr_wr_data: dst_enable
//
// One beat per cycle while rsp_chan is not stalled: the whole tick/load
// update is one combinational pass from the state registers into the state
// and result registers. Result appears in the cycle after the beat is taken.
// A held result blocks req only while rsp_chan is stalled; a result taken in
// the same cycle frees the slot for the next request.
// Reset (synchronous) sets 2019-01-01 00:00:00, Tuesday, daylight saving off.
`include "calendar_clock_with_dst_assert.svh"

module calendar_clock_with_dst (
   input  logic       clock,
   input  logic       reset,
   cal_dst_chan.sink  req_chan,
   cal_dst_chan.source rsp_chan,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import cal_dst_pkg::*;

   // clock state
   logic [5:0] sec_ff,  sec_in;
   logic [5:0] min_ff,  min_in;
   logic [4:0] hour_ff, hour_in;
   logic [4:0] day_ff,  day_in;
   logic [3:0] month_ff, month_in;
   logic [7:0] year_ff, year_in;
   logic [2:0] wday_ff, wday_in;
   logic       leap_ff, leap_in;
   logic       dst_done_ff, dst_done_in;
   logic       dst_en_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   cal_rsp_type rsp_data_ff,  rsp_data_in;

   cal_req_type req;
   logic        accept;
   logic        rolled;
   logic        shifted;

   assign req             = req_chan.data;
   // slot is free when empty or being drained this cycle
   assign req_chan.ready  = !rsp_valid_ff || rsp_chan.ready;
   assign accept          = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.data   = rsp_data_ff;

   always_comb begin
      sec_in      = sec_ff;
      min_in      = min_ff;
      hour_in     = hour_ff;
      day_in      = day_ff;
      month_in    = month_ff;
      year_in     = year_ff;
      wday_in     = wday_ff;
      leap_in     = leap_ff;
      dst_done_in = dst_done_ff;
      rolled      = 1'b0;
      shifted     = 1'b0;

      if (accept) begin
         if (req.command == CMD_LOAD) begin
            hour_in  = req.load_hours;
            min_in   = req.load_minutes;
            sec_in   = req.load_seconds;
            day_in   = req.load_day;
            month_in = req.load_month;
            year_in  = req.load_year;
            wday_in  = req.load_weekday;
            leap_in  = cal_leap(req.load_year);
         end else if (sec_ff < SEC_MAX) begin
            sec_in = sec_ff + 6'd1;
         end else begin
            sec_in = '0;
            if (min_ff < MIN_MAX) begin
               min_in = min_ff + 6'd1;
            end else begin
               min_in = '0;
               if (hour_ff < HOUR_MAX) begin
                  hour_in = hour_ff + 5'd1;
                  // turning to 3 on a late-month Sunday
                  if (hour_ff == DST_PRE_HOUR && dst_en_ff && wday_ff == WDAY_SUN &&
                      day_ff > DST_MIN_DAY && !dst_done_ff) begin
                     if (month_ff == MONTH_MAR) begin
                        hour_in     = DST_FWD_HOUR;
                        dst_done_in = 1'b1;
                        shifted     = 1'b1;
                     end else if (month_ff == MONTH_OCT) begin
                        hour_in     = DST_BACK_HOUR;
                        dst_done_in = 1'b1;
                        shifted     = 1'b1;
                     end
                  end
               end else begin
                  // midnight: advance the date
                  hour_in     = '0;
                  dst_done_in = 1'b0;
                  rolled      = 1'b1;
                  if (month_ff == MONTH_FEB) begin
                     if (day_ff < DAY_FEB) begin
                        day_in = day_ff + 5'd1;
                     end else if (day_ff == DAY_FEB && leap_ff) begin
                        day_in = DAY_FEB_LEAP;
                     end else begin
                        month_in = MONTH_MAR;
                        day_in   = DAY_FIRST;
                     end
                  end else if (cal_long_month(month_ff)) begin
                     if (day_ff < DAY_LONG) begin
                        day_in = day_ff + 5'd1;
                     end else if (month_ff == MONTH_DEC) begin
                        year_in  = year_ff + 8'd1;   // wraps 255 -> 0
                        leap_in  = cal_leap(year_ff + 8'd1);
                        month_in = MONTH_JAN;
                        day_in   = DAY_FIRST;
                     end else begin
                        month_in = month_ff + 4'd1;
                        day_in   = DAY_FIRST;
                     end
                  end else begin
                     // 30-day months; out-of-range months count as 30 days too
                     if (day_ff < DAY_SHORT) begin
                        day_in = day_ff + 5'd1;
                     end else begin
                        month_in = (month_ff >= MONTH_JAN && month_ff <= MONTH_NOV) ?
                                   month_ff + 4'd1 : MONTH_JAN;
                        day_in   = DAY_FIRST;
                     end
                  end
                  wday_in = (wday_ff >= WDAY_SAT) ? WDAY_SUN : wday_ff + 3'd1;
               end
            end
         end
      end

      rsp_data_in.hours        = hour_in;
      rsp_data_in.minutes      = min_in;
      rsp_data_in.seconds      = sec_in;
      rsp_data_in.day          = day_in;
      rsp_data_in.month        = month_in;
      rsp_data_in.year         = year_in;
      rsp_data_in.weekday      = wday_in;
      rsp_data_in.leap_year    = leap_in;
      rsp_data_in.day_rollover = rolled;
      rsp_data_in.dst_shifted  = shifted;

      rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff       <= RST_SEC;
         min_ff       <= RST_MIN;
         hour_ff      <= RST_HOUR;
         day_ff       <= RST_DAY;
         month_ff     <= RST_MONTH;
         year_ff      <= RST_YEAR;
         wday_ff      <= RST_WDAY;
         leap_ff      <= 1'b0;
         dst_done_ff  <= 1'b0;
         dst_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sec_ff       <= sec_in;
         min_ff       <= min_in;
         hour_ff      <= hour_in;
         day_ff       <= day_in;
         month_ff     <= month_in;
         year_ff      <= year_in;
         wday_ff      <= wday_in;
         leap_ff      <= leap_in;
         dst_done_ff  <= dst_done_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            dst_en_ff <= csr_wr_data;
         end
      end
   end

   // payload register, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ---- checks ----
   `CAL_ASSERT_ALWAYS(a_stall_blocks_req, clock,
      (rsp_valid_ff && !rsp_chan.ready) |-> !req_chan.ready, "req taken while result stalled")
   `CAL_ASSERT(a_accept_gives_rsp, clock, reset,
      accept |=> rsp_valid_ff, "accepted beat produced no result")
   `CAL_ASSERT(a_shift_hour, clock, reset,
      (rsp_valid_ff && rsp_data_ff.dst_shifted) |->
      ((rsp_data_ff.hours == DST_FWD_HOUR || rsp_data_ff.hours == DST_BACK_HOUR) &&
       !rsp_data_ff.day_rollover && dst_done_ff), "bad daylight saving shift")
   `CAL_ASSERT(a_leap_match, clock, reset,
      rsp_valid_ff |-> (rsp_data_ff.leap_year == cal_leap(rsp_data_ff.year)),
      "leap flag does not match year")

endmodule
